>>> design/slxfr_pkg.sv
// Shared types and constants for the sync/length/XOR frame receiver.
package slxfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h51;
    localparam logic [7:0] SYNC_SECOND = 8'hA5;

    // Header bytes before the payload plus the trailing checksum byte.
    localparam logic [16:0] FRAME_OVERHEAD = 17'd7;

    localparam int unsigned POS_W = 17;
    localparam int unsigned LEN_W = 16;

    // Byte positions of the fixed header fields.
    localparam logic [POS_W-1:0] POS_SYNC_FIRST  = 17'd0;
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = 17'd1;
    localparam logic [POS_W-1:0] POS_COMMAND     = 17'd2;
    localparam logic [POS_W-1:0] POS_LEN_HIGH    = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_LOW     = 17'd4;

    typedef enum logic [2:0] {
        ST_IN_FRAME  = 3'd0,
        ST_GOOD      = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_SYNC_LOST = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]       frame_byte;
        logic [POS_W-1:0] byte_position;
        logic             last;
        t_status          frame_status;
    } t_result;

endpackage

>>> design/slxfr_core.sv
// Frame parser: state registers and the per-byte next-state and result logic.
module slxfr_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [15:0]                  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic [7:0]                   i_in_byte,
    input  logic                         i_advance,
    output logic                         o_res_valid,
    output slxfr_pkg::t_result           o_res
);

    logic [slxfr_pkg::POS_W-1:0] r_count, n_count;
    logic [7:0]                  r_xor, n_xor;
    logic [slxfr_pkg::LEN_W-1:0] r_len, n_len;
    logic [slxfr_pkg::LEN_W-1:0] r_max_len;

    logic [7:0]                  xor_acc;
    logic [slxfr_pkg::LEN_W-1:0] full_len;
    logic [slxfr_pkg::POS_W-1:0] count_inc;
    logic [slxfr_pkg::POS_W-1:0] frame_end;

    assign xor_acc   = r_xor ^ i_in_byte;
    assign full_len  = {r_len[15:8], i_in_byte};
    assign count_inc = r_count + 17'd1;
    assign frame_end = {1'b0, r_len} + slxfr_pkg::FRAME_OVERHEAD;

    always_comb begin
        n_count = r_count;
        n_xor   = xor_acc;
        n_len   = r_len;
        o_res_valid         = i_in_valid;
        o_res.frame_byte    = i_in_byte;
        o_res.byte_position = r_count;
        o_res.last          = 1'b0;
        o_res.frame_status  = slxfr_pkg::ST_IN_FRAME;
        case (r_count)
            slxfr_pkg::POS_SYNC_FIRST: begin
                // Hunting: only the first sync byte starts a frame.
                if (i_in_byte == slxfr_pkg::SYNC_FIRST) begin
                    n_count = count_inc;
                    n_xor   = i_in_byte;
                end else begin
                    o_res_valid = 1'b0;
                    n_xor       = r_xor;
                end
            end
            slxfr_pkg::POS_SYNC_SECOND: begin
                if (i_in_byte != slxfr_pkg::SYNC_SECOND) begin
                    o_res.last         = 1'b1;
                    o_res.frame_status = slxfr_pkg::ST_SYNC_LOST;
                    n_count = '0;
                    n_xor   = '0;
                    n_len   = '0;
                end else begin
                    n_count = count_inc;
                end
            end
            slxfr_pkg::POS_COMMAND: begin
                n_count = count_inc;
            end
            slxfr_pkg::POS_LEN_HIGH: begin
                n_len   = {i_in_byte, 8'h00};
                n_count = count_inc;
            end
            slxfr_pkg::POS_LEN_LOW: begin
                if (full_len > r_max_len) begin
                    o_res.last         = 1'b1;
                    o_res.frame_status = slxfr_pkg::ST_TOO_LONG;
                    n_count = '0;
                    n_xor   = '0;
                    n_len   = '0;
                end else begin
                    n_len   = full_len;
                    n_count = count_inc;
                end
            end
            default: begin
                // Reserved byte, payload and checksum byte.
                if (count_inc >= frame_end) begin
                    o_res.last         = 1'b1;
                    o_res.frame_status = (xor_acc == 8'h00) ? slxfr_pkg::ST_GOOD
                                                            : slxfr_pkg::ST_BAD_SUM;
                    n_count = '0;
                    n_xor   = '0;
                    n_len   = '0;
                end else begin
                    n_count = count_inc;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_xor     <= '0;
            r_len     <= '0;
            r_max_len <= 16'd1024;
        end else begin
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
            if (i_advance) begin
                r_count <= n_count;
                r_xor   <= n_xor;
                r_len   <= n_len;
            end
        end
    end

    // A byte that ends or aborts a frame sends the parser back to hunting.
    a_last_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_res_valid && o_res.last) |=> (r_count == '0))
        else $error("parser did not return to hunting after the last byte");

    // While hunting, the checksum and length registers are clear.
    a_hunt_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_xor == 8'h00 && r_len == '0))
        else $error("stale checksum or length while hunting");

    // Inside the body the count never passes the checksum byte position.
    a_count_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > slxfr_pkg::POS_LEN_LOW) |-> (r_count < frame_end))
        else $error("byte count ran past the end of the frame");

endmodule

>>> design/sync_length_xor_frame_receiver.sv
// Top level of the sync/length/XOR frame receiver with input and result registers.
//
//  Channel   Direction  Payload
//  -------   ---------  ----------------------------------------------------
//  s (in)    slave      tdata: rx_byte [7:0]
//  m (out)   master     tdata: frame_byte [7:0], byte_position [24:8];
//                       tlast: last; tuser: frame_status [2:0]
//  cfg       slave      data: max_payload_length [15:0]
//
// One byte is accepted per cycle unless the result side stalls. An accepted byte
// is held in the input register while the parser logic turns it into a result,
// which is then loaded into the result register and offered from there. Reset is
// synchronous and active low; it returns the parser to sync hunting and sets the
// maximum payload length to 1024. A full result register that is not taken stalls
// only a byte that yields a result; the input register then holds and the input
// side stops accepting.
module sync_length_xor_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] frame_byte, [24:8] byte_position, rest zero
    output logic        o_m_tlast,   // last
    output logic [2:0]  o_m_tuser,   // [2:0] frame_status
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data   // [15:0] max_payload_length
);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Result register.
    logic                r_out_valid;
    slxfr_pkg::t_result  r_out;

    logic                res_valid;
    slxfr_pkg::t_result  res;
    logic                advance;

    // The held byte moves on when it makes no result or the result register
    // has room (empty, or being emptied in this cycle).
    assign advance    = r_in_valid && (!res_valid || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    slxfr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (r_in_valid),
        .i_in_byte   (r_in_byte),
        .i_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.byte_position, r_out.frame_byte};
    assign o_m_tlast  = r_out.last;
    assign o_m_tuser  = r_out.frame_status;

endmodule
